// ===== sv/sound_direction_vote_assert.svh =====
// Assertion macros shared by the sound direction vote RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef SOUND_DIRECTION_VOTE_ASSERT_SVH
`define SOUND_DIRECTION_VOTE_ASSERT_SVH
// Implication checked on every edge out of reset.
`define SDV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdv check failed");
// Next-cycle implication checked out of reset.
`define SDV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdv check failed");
`endif

// ===== sv/sdv_pkg.sv =====
// Shared types and constants of the sound direction vote block.
// No dependencies.
package sdv_pkg;
  localparam int HistDepth = 32;
  localparam int SlotW = 5;
  localparam int CntW = 6;
  localparam int NumBuckets = 10;
  localparam int TopBucket = 9;
  localparam logic [7:0] AngleMax = 8'd180;
  localparam logic [7:0] AngleDefault = 8'd90;
  localparam logic [15:0] MaxAgeReset = 16'd1000;
  localparam logic [9:0] UsPerMs = 10'd1000;

  localparam logic [1:0] ReqStore = 2'd0;
  localparam logic [1:0] ReqSelect = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  angle_deg;
    logic [31:0] frame_energy;
    logic [15:0] diff_permille;
    logic [62:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  chosen_deg;
    logic [8:0]  used_count;
    logic [7:0]  min_deg;
    logic [7:0]  max_deg;
    logic [31:0] top_energy;
    logic [15:0] chosen_diff;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input word
    logic do_store;  // write ring slot
    logic do_clear;  // empty history
    logic limit_mul; // compute age limit
    logic pass1_clr; // clear accumulators
    logic pass1;     // first walk step at index
    logic bsum_step; // neighbourhood step at bucket index
    logic pass2;     // second walk step at index
    logic finish;    // form result
    logic [SlotW:0] idx;
  } sdv_cmd_t;

  typedef struct packed {
    logic [1:0]     req;
  } sdv_sts_t;

  // Bucket of an angle: (deg + 10) / 20, capped at 9, via a compare chain.
  function automatic logic [3:0] bucket_of(input logic [7:0] deg);
    logic [8:0] t;
    t = {1'b0, deg} + 9'd10;
    if (t >= 9'd180) return 4'd9;
    else if (t >= 9'd160) return 4'd8;
    else if (t >= 9'd140) return 4'd7;
    else if (t >= 9'd120) return 4'd6;
    else if (t >= 9'd100) return 4'd5;
    else if (t >= 9'd80) return 4'd4;
    else if (t >= 9'd60) return 4'd3;
    else if (t >= 9'd40) return 4'd2;
    else if (t >= 9'd20) return 4'd1;
    else return 4'd0;
  endfunction
endpackage

// ===== sv/sdv_datapath.sv =====
// Datapath of the sound direction vote: history memory, accumulators, result.
// Depends on sdv_pkg.
module sdv_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sdv_pkg::in_word_t in_word,
  input  logic [15:0]       max_age_ms,
  input  sdv_pkg::sdv_cmd_t cmd,
  output sdv_pkg::sdv_sts_t sts,
  output sdv_pkg::out_word_t res
);
  localparam int SW = sdv_pkg::SlotW;

  // History memory, one read port registered.
  logic [7:0]  mem_ang [sdv_pkg::HistDepth];
  logic [31:0] mem_en  [sdv_pkg::HistDepth];
  logic [15:0] mem_df  [sdv_pkg::HistDepth];
  logic [62:0] mem_tm  [sdv_pkg::HistDepth];
  logic [7:0]  rd_ang_r;
  logic [31:0] rd_en_r;
  logic [15:0] rd_df_r;
  logic [62:0] rd_tm_r;

  sdv_pkg::in_word_t w_r;
  logic [SW-1:0]  wslot_r;
  logic [sdv_pkg::CntW-1:0] fill_r;
  logic           last_valid_r;
  logic [7:0]     last_angle_r;
  logic [62:0]    last_time_r;
  logic [25:0]    limit_r;
  logic [36:0]    bucket_r [sdv_pkg::NumBuckets];
  logic [38:0]    best_sum_r;
  logic [3:0]     best_r;
  logic [8:0]     count_r;
  logic [7:0]     mn_r, mx_r, pk_deg_r, sel_deg_r;
  logic [31:0]    peak_r, sel_e_r;
  logic [15:0]    pk_diff_r, sel_diff_r;
  logic           rd_ok_r;
  sdv_pkg::out_word_t res_r;
  sdv_pkg::out_word_t res_nxt;

  logic [7:0]  ang_sat;
  logic        fresh;
  logic [62:0] age;
  logic [3:0]  bk;
  logic [3:0]  bi;
  logic [38:0] s3;
  logic        in_clu;
  logic [63:0] lage;

  assign ang_sat = (w_r.angle_deg > sdv_pkg::AngleMax) ? sdv_pkg::AngleMax : w_r.angle_deg;
  assign age = w_r.time_us - rd_tm_r;
  assign fresh = rd_ok_r && (rd_tm_r != '0) && (rd_tm_r <= w_r.time_us)
                 && ({26'd0, age[62:26]} == 63'd0 ? (age[25:0] <= limit_r) : 1'b0);
  assign bk = sdv_pkg::bucket_of(rd_ang_r);
  assign bi = cmd.idx[3:0];
  assign lage = {1'b0, w_r.time_us} - {1'b0, last_time_r};
  assign in_clu = ({1'b0, bk} + 5'd1 >= {1'b0, best_r}) && ({1'b0, bk} <= {1'b0, best_r} + 5'd1);

  // Sum of a bucket and its neighbours.
  always_comb begin
    s3 = {2'b0, bucket_r[bi]};
    if (bi != 4'd0) s3 = s3 + {2'b0, bucket_r[bi - 4'd1]};
    if (bi != 4'(sdv_pkg::TopBucket)) s3 = s3 + {2'b0, bucket_r[bi + 4'd1]};
  end

  // Form the select result: fresh cluster, latest fallback or nothing.
  always_comb begin
    res_nxt = '0;
    res_nxt.chosen_deg = sdv_pkg::AngleDefault;
    if (count_r == '0) begin
      if (last_valid_r && !lage[63] && lage[62:0] <= {37'd0, limit_r}) begin
        res_nxt.found = 1'b1;
        res_nxt.chosen_deg = last_angle_r;
        res_nxt.used_count = 9'd1;
        res_nxt.min_deg = last_angle_r;
        res_nxt.max_deg = last_angle_r;
      end
    end else begin
      res_nxt.found = 1'b1;
      res_nxt.chosen_deg = sel_deg_r;
      res_nxt.used_count = count_r;
      res_nxt.min_deg = mn_r;
      res_nxt.max_deg = mx_r;
      res_nxt.top_energy = peak_r;
      res_nxt.chosen_diff = sel_diff_r;
    end
  end

  // Write and read the ring.
  always_ff @(posedge clk) begin
    if (cmd.do_store) begin
      mem_ang[wslot_r] <= ang_sat;
      mem_en[wslot_r]  <= w_r.frame_energy;
      mem_df[wslot_r]  <= w_r.diff_permille;
      mem_tm[wslot_r]  <= w_r.time_us;
    end
    rd_ang_r <= mem_ang[cmd.idx[SW-1:0]];
    rd_en_r  <= mem_en[cmd.idx[SW-1:0]];
    rd_df_r  <= mem_df[cmd.idx[SW-1:0]];
    rd_tm_r  <= mem_tm[cmd.idx[SW-1:0]];
  end

  // Control state of the history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      fill_r <= '0;
      last_valid_r <= 1'b0;
      last_angle_r <= sdv_pkg::AngleDefault;
      last_time_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= ({1'b0, cmd.idx} < {1'b0, fill_r});
      if (cmd.do_clear) begin
        wslot_r <= '0;
        fill_r <= '0;
        last_valid_r <= 1'b0;
        last_angle_r <= sdv_pkg::AngleDefault;
        last_time_r <= '0;
      end else if (cmd.do_store) begin
        wslot_r <= wslot_r + SW'(1);
        if (fill_r != sdv_pkg::CntW'(sdv_pkg::HistDepth)) fill_r <= fill_r + sdv_pkg::CntW'(1);
        last_valid_r <= 1'b1;
        last_angle_r <= ang_sat;
        last_time_r <= w_r.time_us;
      end
    end
  end

  // Query accumulators and result.
  always_ff @(posedge clk) begin
    if (cmd.load) w_r <= in_word;
    if (cmd.limit_mul) limit_r <= 26'(max_age_ms) * 26'(sdv_pkg::UsPerMs);
    if (cmd.pass1_clr) begin
      for (int k = 0; k < sdv_pkg::NumBuckets; k++) bucket_r[k] <= '0;
      count_r <= '0; mn_r <= sdv_pkg::AngleMax; mx_r <= '0; peak_r <= '0;
      pk_deg_r <= sdv_pkg::AngleDefault; pk_diff_r <= '0;
      best_sum_r <= '0; best_r <= '0; sel_e_r <= '0;
    end
    if (cmd.pass1 && fresh) begin
      bucket_r[bk] <= bucket_r[bk] + {5'd0, rd_en_r};
      count_r <= count_r + 9'd1;
      if (rd_ang_r < mn_r) mn_r <= rd_ang_r;
      if (rd_ang_r > mx_r) mx_r <= rd_ang_r;
      if (rd_en_r > peak_r) begin
        peak_r <= rd_en_r; pk_deg_r <= rd_ang_r; pk_diff_r <= rd_df_r;
      end
    end
    if (cmd.bsum_step) begin
      if (s3 > best_sum_r) begin
        best_sum_r <= s3; best_r <= bi;
      end
      sel_deg_r <= pk_deg_r;
      sel_diff_r <= pk_diff_r;
    end
    if (cmd.pass2 && fresh && in_clu && rd_en_r > sel_e_r) begin
      sel_e_r <= rd_en_r; sel_deg_r <= rd_ang_r; sel_diff_r <= rd_df_r;
    end
    if (cmd.finish) res_r <= res_nxt;
  end

  assign sts.req = w_r.req_type;
  assign res = res_r;

`include "sound_direction_vote_assert.svh"
  `SDV_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= sdv_pkg::CntW'(sdv_pkg::HistDepth))
  `SDV_ASSERT_NEXT(a_clear_empties, cmd.do_clear, fill_r == '0 && !last_valid_r)
  `SDV_ASSERT_NEXT(a_store_valid, cmd.do_store && !cmd.do_clear, last_valid_r)
endmodule

// ===== sv/sdv_ctrl.sv =====
// Sequencer of the sound direction vote: handshakes and query walk order.
// Depends on sdv_pkg.
module sdv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sdv_pkg::sdv_sts_t sts,
  output sdv_pkg::sdv_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_P1, S_BSUM, S_P2, S_FIN, S_OUT
  } state_t;

  localparam logic [5:0] LastIdx = 6'(sdv_pkg::HistDepth);

  state_t state_r;
  logic [5:0] idx_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Commands from state.
  always_comb begin
    cmd = '0;
    cmd.idx = idx_r;
    cmd.load = in_valid && in_ready;
    case (state_r)
      S_DECODE: begin
        cmd.do_store = (sts.req == sdv_pkg::ReqStore);
        cmd.do_clear = (sts.req == sdv_pkg::ReqClear);
        cmd.limit_mul = 1'b1;
        cmd.pass1_clr = 1'b1;
      end
      S_P1:   cmd.pass1 = (idx_r != 6'd0);
      S_BSUM: cmd.bsum_step = 1'b1;
      S_P2:   cmd.pass2 = (idx_r != 6'd0);
      S_FIN:  cmd.finish = 1'b1;
      default: ;
    endcase
    // Read address runs one ahead of evaluation in the walks.
    if (state_r == S_P1 || state_r == S_P2) cmd.idx = idx_r;
  end

  // Walk the ring twice; evaluation at idx uses data read at idx-1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DECODE;
        S_DECODE: begin
          idx_r <= '0;
          state_r <= (sts.req == sdv_pkg::ReqSelect) ? S_P1 : S_IDLE;
        end
        S_P1: begin
          if (idx_r == LastIdx) begin
            idx_r <= '0; state_r <= S_BSUM;
          end else idx_r <= idx_r + 6'd1;
        end
        S_BSUM: begin
          if (idx_r == 6'(sdv_pkg::TopBucket)) begin
            idx_r <= '0; state_r <= S_P2;
          end else idx_r <= idx_r + 6'd1;
        end
        S_P2: begin
          if (idx_r == LastIdx) state_r <= S_FIN;
          else idx_r <= idx_r + 6'd1;
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "sound_direction_vote_assert.svh"
  `SDV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SDV_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `SDV_ASSERT_NEXT(a_fin_to_out, state_r == S_FIN, out_valid)
endmodule

// ===== sv/sound_direction_vote.sv =====
// Top level of the sound direction vote block.
// Depends on sdv_pkg, sdv_ctrl and sdv_datapath.
//
// channel  direction  word type             handshake
// in_      input      sdv_pkg::in_word_t    in_valid / in_ready
// out_     output     sdv_pkg::out_word_t   out_valid / out_ready
// cfg_     input      16-bit max_age_ms     cfg_valid / cfg_ready
//
// Store, clear and ignored codes pass through decode and back to idle;
// a select runs decode, two walks over the registered-read history memory,
// a bucket scan, a step that forms the result and an output state that waits
// for out_ready before the block returns to idle.
// Reset is synchronous; history contents need no clearing, the fill count guards them.
// One word is in flight at a time; a stalled result holds the block.
module sound_direction_vote (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdv_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sdv_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  logic [15:0] max_age_r;
  sdv_pkg::sdv_cmd_t cmd;
  sdv_pkg::sdv_sts_t sts;

  assign cfg_ready = 1'b1;

  // Hold the age limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) max_age_r <= sdv_pkg::MaxAgeReset;
    else if (cfg_valid) max_age_r <= cfg_data;
  end

  sdv_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  sdv_datapath u_dp (
    .clk, .rst_n, .in_word(in_data), .max_age_ms(max_age_r), .cmd, .sts, .res(out_data)
  );
endmodule

// ===== sim/sound_direction_vote_test.sv =====
// Testbench for sound_direction_vote: direction voting over a ring of samples.
// Depends on sdv_pkg and the sound_direction_vote RTL; predicts every select result.
`timescale 1ns / 100ps

module sound_direction_vote_test;
  localparam int StallLimit = 20000;
  localparam int SettleCycles = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sdv_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdv_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  sound_direction_vote dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [7:0]  ring_angle [sdv_pkg::HistDepth];
  logic [31:0] ring_energy [sdv_pkg::HistDepth];
  logic [15:0] ring_diff [sdv_pkg::HistDepth];
  logic [63:0] ring_time [sdv_pkg::HistDepth];
  int unsigned ring_slot;
  int unsigned ring_fill;
  bit          newest_ok;
  logic [7:0]  latest_angle;
  logic [63:0] latest_time;
  logic [15:0] age_limit_ms;

  sdv_pkg::out_word_t pending_votes[$];
  int          fail_count = 0;
  int          vote_count = 0;
  int          word_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] now_us = 64'd1000;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void forget_history();
    for (int i = 0; i < sdv_pkg::HistDepth; i++) begin
      ring_angle[i] = '0;
      ring_energy[i] = '0;
      ring_diff[i] = '0;
      ring_time[i] = '0;
    end
    ring_slot = 0;
    ring_fill = 0;
    newest_ok = 1'b0;
    latest_angle = sdv_pkg::AngleDefault;
    latest_time = '0;
  endfunction

  function automatic int unsigned angle_bucket(logic [7:0] deg);
    int unsigned b;
    b = (int'(deg) + 10) / 20;
    return b > sdv_pkg::TopBucket ? sdv_pkg::TopBucket : b;
  endfunction

  function automatic bit sample_fresh(int i, logic [63:0] now, logic [63:0] lim);
    if (ring_time[i] == 0 || ring_time[i] > now) return 1'b0;
    return (now - ring_time[i]) <= lim;
  endfunction

  // Apply one word to the predictor; queue the vote a select yields.
  function automatic void predict_vote(sdv_pkg::in_word_t w);
    logic [63:0] now, lim, best_sum, s;
    logic [63:0] bsum [sdv_pkg::NumBuckets];
    logic [31:0] peak, sel_e;
    logic [7:0]  mn, mx, peak_deg, sel_deg, ang;
    logic [15:0] peak_diff, sel_diff;
    int unsigned cnt, best, bk;
    sdv_pkg::out_word_t r;
    now = {1'b0, w.time_us};
    lim = 64'(age_limit_ms) * 64'd1000;
    if (w.req_type == sdv_pkg::ReqStore) begin
      ang = w.angle_deg > sdv_pkg::AngleMax ? sdv_pkg::AngleMax : w.angle_deg;
      latest_angle = ang;
      latest_time = now;
      newest_ok = 1'b1;
      ring_angle[ring_slot] = ang;
      ring_energy[ring_slot] = w.frame_energy;
      ring_diff[ring_slot] = w.diff_permille;
      ring_time[ring_slot] = now;
      ring_slot = (ring_slot + 1) % sdv_pkg::HistDepth;
      if (ring_fill < sdv_pkg::HistDepth) ring_fill++;
      return;
    end
    if (w.req_type == sdv_pkg::ReqClear) begin
      forget_history();
      return;
    end
    if (w.req_type != sdv_pkg::ReqSelect) return;
    for (int b = 0; b < sdv_pkg::NumBuckets; b++) bsum[b] = '0;
    peak = '0; cnt = 0; mn = sdv_pkg::AngleMax; mx = '0;
    peak_deg = sdv_pkg::AngleDefault; peak_diff = '0;
    for (int i = 0; i < ring_fill; i++) begin
      if (!sample_fresh(i, now, lim)) continue;
      bsum[angle_bucket(ring_angle[i])] += ring_energy[i];
      cnt++;
      if (ring_angle[i] < mn) mn = ring_angle[i];
      if (ring_angle[i] > mx) mx = ring_angle[i];
      if (ring_energy[i] > peak) begin
        peak = ring_energy[i];
        peak_deg = ring_angle[i];
        peak_diff = ring_diff[i];
      end
    end
    r = '0;
    r.chosen_deg = sdv_pkg::AngleDefault;
    if (cnt == 0) begin
      if (newest_ok && now >= latest_time && (now - latest_time) <= lim) begin
        r.found = 1'b1;
        r.chosen_deg = latest_angle;
        r.used_count = 9'd1;
        r.min_deg = latest_angle;
        r.max_deg = latest_angle;
      end
      pending_votes.push_back(r);
      return;
    end
    best = 0; best_sum = '0;
    for (int b = 0; b < sdv_pkg::NumBuckets; b++) begin
      s = bsum[b];
      if (b > 0) s += bsum[b-1];
      if (b < sdv_pkg::TopBucket) s += bsum[b+1];
      if (s > best_sum) begin
        best_sum = s;
        best = b;
      end
    end
    sel_e = '0; sel_deg = peak_deg; sel_diff = peak_diff;
    for (int i = 0; i < ring_fill; i++) begin
      if (!sample_fresh(i, now, lim)) continue;
      bk = angle_bucket(ring_angle[i]);
      if (bk + 1 >= best && bk <= best + 1 && ring_energy[i] > sel_e) begin
        sel_e = ring_energy[i];
        sel_deg = ring_angle[i];
        sel_diff = ring_diff[i];
      end
    end
    r.found = 1'b1;
    r.chosen_deg = sel_deg;
    r.used_count = 9'(cnt);
    r.min_deg = mn;
    r.max_deg = mx;
    r.top_energy = peak;
    r.chosen_diff = sel_diff;
    pending_votes.push_back(r);
  endfunction

  // Send one word, idling at random first; predict on acceptance.
  task automatic send_word(sdv_pkg::in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vote(w);
    word_count++;
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    age_limit_ms = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic sdv_pkg::in_word_t make_word(logic [1:0] req, logic [7:0] ang,
                                                  logic [31:0] e, logic [15:0] d,
                                                  logic [62:0] t);
    sdv_pkg::in_word_t w;
    w.req_type = req; w.angle_deg = ang; w.frame_energy = e;
    w.diff_permille = d; w.time_us = t;
    return w;
  endfunction

  // Receiver: random stall, compare each accepted word.
  always @(posedge clk) begin
    sdv_pkg::out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_votes.size() == 0) begin
        $display("%t: unexpected result %h", $realtime, out_data);
        fail_count++;
      end else begin
        exp_w = pending_votes.pop_front();
        vote_count++;
        if (out_data !== exp_w) begin
          $display("%t: mismatch expected %h actual %h", $realtime, exp_w, out_data);
          fail_count++;
        end
      end
    end
    out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd5));      // empty ring
    send_word(make_word(sdv_pkg::ReqStore, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 63'd0));
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd10));     // zero-time latest
    send_word(make_word(sdv_pkg::ReqStore, 8'd0, 32'd0, 16'd0, 63'd100));
    send_word(make_word(sdv_pkg::ReqStore, 8'd181, 32'd0, 16'd7, 63'd200));
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd300));    // all energies zero
    send_word(make_word(sdv_pkg::ReqStore, 8'd30, 32'd500, 16'd11, 63'd400));
    send_word(make_word(sdv_pkg::ReqStore, 8'd50, 32'd500, 16'd22, 63'd410));
    send_word(make_word(sdv_pkg::ReqStore, 8'd170, 32'd900, 16'd33, 63'd420));
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd500));    // cluster beats peak
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd410));    // some in future
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd50));     // all future
    send_word(make_word(sdv_pkg::ReqUnused, 8'hFF, '1, '1, '1));        // unused code
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd1_000_420)); // age edge
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd5_000_000)); // all stale
    send_word(make_word(sdv_pkg::ReqClear, 8'd0, '0, '0, 63'd0));
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, 63'd600));
    send_word(make_word(sdv_pkg::ReqStore, 8'd90, 32'd1, 16'd1, '1));
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, '1));         // max time
    write_age_limit(16'd0);
    send_word(make_word(sdv_pkg::ReqSelect, 8'd0, '0, '0, '1));         // zero age limit
    send_word(make_word(sdv_pkg::ReqClear, 8'd0, '0, '0, 63'd0));
  endtask

  // Random phase: mostly realistic store bursts with a select, plus noise.
  task automatic test_random(int n_words, int idle_pct, int stall_pct);
    sdv_pkg::in_word_t w;
    int unsigned pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(99);
      now_us += $urandom_range(300_000);
      w = make_word(sdv_pkg::ReqStore, 8'($urandom_range(180)), $urandom,
                    16'($urandom), 63'(now_us));
      if ($urandom_range(9) == 0) w.frame_energy = $urandom_range(3);
      if ($urandom_range(19) == 0) w.angle_deg = 8'($urandom);
      if (pick < 30) w.req_type = sdv_pkg::ReqSelect;
      else if (pick < 33) w.req_type = sdv_pkg::ReqClear;
      else if (pick < 35) w.req_type = sdv_pkg::ReqUnused;
      if (pick >= 35 && pick < 38) w.time_us = 63'({$urandom, $urandom});
      if (pick < 30 && $urandom_range(9) == 0) w.time_us = 63'($urandom_range(2000));
      send_word(w);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    age_limit_ms = sdv_pkg::MaxAgeReset;
    forget_history();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_age_limit(16'd60000);
    test_random(250, 0, 0);
    write_age_limit(16'd1000);
    test_random(250, 66, 0);
    wait_drained();   // hold sender until every result is back
    write_age_limit(16'd65535);
    test_random(250, 0, 66);
    write_age_limit(16'd1);
    test_random(100, 35, 35);
    write_age_limit(16'd700);
    test_random(250, 35, 35);
    wait_drained();
    $display("Covered %0d words and %0d votes over several age limits and idle mixes.",
             word_count, vote_count);
    if (fail_count == 0 && pending_votes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/sdv_pkg.sv
sv/sdv_datapath.sv
sv/sdv_ctrl.sv
sv/sound_direction_vote.sv
sim/sound_direction_vote_test.sv
